FILE: hw/rtl/swd_pkg.sv
// swd_pkg: shared types and constants of the serial wire debug master bit engine
// used by the top, front, queue and back modules of the engine; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package swd_pkg;

  // command kinds carried by an input item
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_XFER   = 2'd1,
    KIND_LRST   = 2'd2,
    KIND_SWITCH = 2'd3
  } kind_e;

  // sequence lengths and the switch pattern
  localparam logic [15:0] SWITCH_PATTERN = 16'hE79E;
  localparam logic [8:0]  SWITCH_BITS    = 9'd16;
  localparam logic [7:0]  REQ_BITS       = 8'd8;
  localparam logic [7:0]  WORD_BITS      = 8'd32;

  // reset value of the line reset length register
  localparam logic [7:0]  LRST_LEN_RESET = 8'd55;

  // default depth of the queue between front and back
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // register index of the line reset length
  localparam logic REG_LRST_LEN = 1'b0;

  // classified item as it travels from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  req;
    logic        rnw;
    logic [31:0] wdata;
    logic        wpar;
    logic        line_in;
  } cmd_entry_t;

  // one result item
  typedef struct packed {
    logic        line_out;
    logic        line_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack_code;
    logic [31:0] read_word;
    logic        parity_fault;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/swd_if.sv
// swd_cmd_if and swd_res_if: valid/ready channels of the bit engine
// payload widths follow the item fields; no package dependency
`timescale 1ns / 1ps
`default_nettype none

interface swd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ap_not_dp;
  logic        read_not_write;
  logic [1:0]  reg_addr;
  logic [31:0] write_data;
  logic        line_in;

  modport source (
    output valid, kind, ap_not_dp, read_not_write, reg_addr, write_data, line_in,
    input  ready
  );
  modport sink (
    input  valid, kind, ap_not_dp, read_not_write, reg_addr, write_data, line_in,
    output ready
  );
endinterface

interface swd_res_if;
  logic        valid;
  logic        ready;
  logic        line_out;
  logic        line_drive;
  logic        clock_pulse;
  logic        busy_res;
  logic        done_res;
  logic [2:0]  ack_code;
  logic [31:0] read_word;
  logic        parity_fault;

  modport source (
    output valid, line_out, line_drive, clock_pulse, busy_res, done_res, ack_code,
           read_word, parity_fault,
    input  ready
  );
  modport sink (
    input  valid, line_out, line_drive, clock_pulse, busy_res, done_res, ack_code,
           read_word, parity_fault,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/swd_master_bit_engine_core.sv
// swd_master_bit_engine_core: top level of the serial wire debug master bit engine
// depends on swd_pkg, swd_if, swd_front, swd_cmd_fifo and swd_back
`timescale 1ns / 1ps
`default_nettype none

// The engine takes one input item per clock while the queue has room and returns
// one result item per input item, in order. A command item (transfer, line reset,
// switch) loads a sequence; each following tick item advances it by one bit period
// on the wire. The front classifies items into a queue of FifoDepth entries and the
// back sequencer steps one entry per clock into a registered result while that
// result register is free or being drained. The result is registered at the edge
// that pops its entry, so an item passes through its queue slot and then the
// result register. Sustained throughput is one item per clock, set by the
// single-step sequencer; while a result is held, the sequencer waits and the
// queue takes up to FifoDepth more items before the input stalls. The line
// reset length register sits at APB address 0 and must only be written while
// no item is in flight.
module swd_master_bit_engine_core #(
  parameter int unsigned FifoDepth = swd_pkg::CMD_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swd_cmd_if.sink     cmd_i,
  swd_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]          lrst_len_val_q;
  logic                wr_valid;
  logic                wr_ready;
  logic                rd_valid;
  logic                rd_pop;
  swd_pkg::cmd_entry_t wr_entry;
  swd_pkg::cmd_entry_t rd_entry;
  logic                cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swd_pkg::REG_LRST_LEN);
  assign prdata = (paddr[2] == swd_pkg::REG_LRST_LEN) ? {24'd0, lrst_len_val_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrst_len_val_q <= swd_pkg::LRST_LEN_RESET;
    end else begin
      if (cfg_wr) begin
        lrst_len_val_q <= pwdata[7:0];
      end
    end
  end

  swd_front u_front (
    .cmd        (cmd_i),
    .wr_valid_o (wr_valid),
    .wr_ready_i (wr_ready),
    .entry_o    (wr_entry)
  );

  swd_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_entry_i (wr_entry),
    .rd_valid_o (rd_valid),
    .rd_pop_i   (rd_pop),
    .rd_entry_o (rd_entry)
  );

  swd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lrst_len_i (lrst_len_val_q),
    .rd_valid_i (rd_valid),
    .rd_pop_o   (rd_pop),
    .rd_entry_i (rd_entry),
    .res        (res_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/swd_front.sv
// swd_front: accepts input items and classifies them into queue entries
// depends on swd_pkg and swd_cmd_if
`timescale 1ns / 1ps
`default_nettype none

module swd_front (
  swd_cmd_if.sink              cmd,
  output logic                 wr_valid_o,
  input  logic                 wr_ready_i,
  output swd_pkg::cmd_entry_t  entry_o
);

  logic a2;
  logic a3;
  logic req_par;

  // request byte fields
  assign a2      = cmd.reg_addr[0];
  assign a3      = cmd.reg_addr[1];
  assign req_par = cmd.ap_not_dp ^ cmd.read_not_write ^ a2 ^ a3;

  // transfer handshake straight into the queue
  assign cmd.ready  = wr_ready_i;
  assign wr_valid_o = cmd.valid;

  // build the entry: request byte lsb first is start, apndp, rnw, a2, a3, parity, stop, park
  always_comb begin
    entry_o.kind    = swd_pkg::kind_e'(cmd.kind);
    entry_o.req     = {1'b1, 1'b0, req_par, a3, a2, cmd.read_not_write, cmd.ap_not_dp, 1'b1};
    entry_o.rnw     = cmd.read_not_write;
    entry_o.wdata   = cmd.write_data;
    entry_o.wpar    = ^cmd.write_data;
    entry_o.line_in = cmd.line_in;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/swd_cmd_fifo.sv
// swd_cmd_fifo: short queue of classified items between front and back
// depends on swd_pkg
`timescale 1ns / 1ps
`default_nettype none

module swd_cmd_fifo #(
  parameter int unsigned Depth = swd_pkg::CMD_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  swd_pkg::cmd_entry_t wr_entry_i,
  output logic                rd_valid_o,
  input  logic                rd_pop_i,
  output swd_pkg::cmd_entry_t rd_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  swd_pkg::cmd_entry_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign wr_ready_o = (cnt_q != FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_entry_o = slots_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/swd_back.sv
// swd_back: bit sequencer that carries out queued items and holds the result register
// depends on swd_pkg and swd_res_if
`timescale 1ns / 1ps
`default_nettype none

module swd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          lrst_len_i,
  input  logic                rd_valid_i,
  output logic                rd_pop_o,
  input  swd_pkg::cmd_entry_t rd_entry_i,
  swd_res_if.source           res
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_XFER = 2'd1;
  localparam logic [1:0] MODE_LRST = 2'd2;
  localparam logic [1:0] MODE_SWIT = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  req_q, req_d;
  logic [31:0] shift_q, shift_d;
  logic [2:0]  ack_q, ack_d;
  logic        par_q, par_d;
  logic        rflag_q, rflag_d;

  logic        out_valid_q;
  swd_pkg::res_t out_q, out_d;

  logic        drv, lvl, clk_pulse, done;
  logic [8:0]  pos_inc;
  logic [7:0]  off_ack, off_rd, off_wr;
  logic        lin;

  // pop whenever the result register is free or being drained
  assign rd_pop_o = rd_valid_i && (!out_valid_q || res.ready);

  assign pos_inc = {1'b0, pos_q} + 9'd1;
  assign off_ack = pos_q - 8'd9;
  assign off_rd  = pos_q - 8'd12;
  assign off_wr  = pos_q - 8'd13;
  assign lin     = rd_entry_i.line_in;

  // sequence step for one item
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    req_d     = req_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    par_d     = par_q;
    rflag_d   = rflag_q;
    drv       = 1'b0;
    lvl       = 1'b0;
    clk_pulse = 1'b0;
    done      = 1'b0;
    case (rd_entry_i.kind)
      swd_pkg::KIND_XFER: begin
        pos_d   = '0;
        ack_d   = '0;
        req_d   = rd_entry_i.req;
        rflag_d = rd_entry_i.rnw;
        shift_d = rd_entry_i.rnw ? 32'd0 : rd_entry_i.wdata;
        par_d   = rd_entry_i.rnw ? 1'b0 : rd_entry_i.wpar;
        mode_d  = MODE_XFER;
      end
      swd_pkg::KIND_LRST, swd_pkg::KIND_SWITCH: begin
        pos_d   = '0;
        ack_d   = '0;
        rflag_d = 1'b0;
        shift_d = '0;
        par_d   = 1'b0;
        mode_d  = (rd_entry_i.kind == swd_pkg::KIND_LRST) ? MODE_LRST : MODE_SWIT;
        // zero length line reset ends right away
        if (rd_entry_i.kind == swd_pkg::KIND_LRST && lrst_len_i == 8'd0) begin
          mode_d = MODE_IDLE;
          done   = 1'b1;
        end
      end
      default: begin
        if (mode_q != MODE_IDLE) begin
          clk_pulse = 1'b1;
          pos_d     = pos_inc[7:0];
          case (mode_q)
            MODE_LRST: begin
              drv = 1'b1;
              lvl = 1'b1;
              done = (pos_inc >= {1'b0, lrst_len_i});
            end
            MODE_SWIT: begin
              drv = 1'b1;
              lvl = swd_pkg::SWITCH_PATTERN[pos_q[3:0]];
              done = (pos_inc >= swd_pkg::SWITCH_BITS);
            end
            default: begin
              if (pos_q < swd_pkg::REQ_BITS) begin
                // request phase
                drv = 1'b1;
                lvl = req_q[pos_q[2:0]];
              end else if (pos_q == 8'd8) begin
                // turnaround to target
              end else if (pos_q <= 8'd11) begin
                ack_d[off_ack[1:0]] = ack_q[off_ack[1:0]] | lin;
              end else if (rflag_q) begin
                if (pos_q < 8'd12 + swd_pkg::WORD_BITS) begin
                  shift_d[off_rd[4:0]] = shift_q[off_rd[4:0]] | lin;
                  par_d = par_q ^ lin;
                end else if (pos_q == 8'd44) begin
                  par_d = par_q ^ lin;
                end else begin
                  done = 1'b1;
                end
              end else begin
                if (pos_q == 8'd12) begin
                  // turnaround back to master
                end else if (pos_q < 8'd13 + swd_pkg::WORD_BITS) begin
                  drv = 1'b1;
                  lvl = shift_q[off_wr[4:0]];
                end else if (pos_q == 8'd45) begin
                  drv = 1'b1;
                  lvl = par_q;
                end else begin
                  drv  = 1'b1;
                  done = 1'b1;
                end
              end
            end
          endcase
          if (done) begin
            mode_d = MODE_IDLE;
          end
        end
      end
    endcase
  end

  // result fields seen after the step
  always_comb begin
    out_d.line_out     = lvl;
    out_d.line_drive   = drv;
    out_d.clock_pulse  = clk_pulse;
    out_d.busy_res     = (mode_d != MODE_IDLE);
    out_d.done_res     = done;
    out_d.ack_code     = ack_d;
    out_d.read_word    = rflag_d ? shift_d : 32'd0;
    out_d.parity_fault = rflag_d && (pos_d >= 8'd45) && par_d;
  end

  // sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pos_q       <= '0;
      req_q       <= '0;
      shift_q     <= '0;
      ack_q       <= '0;
      par_q       <= 1'b0;
      rflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_pop_o) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        req_q   <= req_d;
        shift_q <= shift_d;
        ack_q   <= ack_d;
        par_q   <= par_d;
        rflag_q <= rflag_d;
      end
      if (rd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (rd_pop_o) begin
      out_q <= out_d;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.line_out     = out_q.line_out;
  assign res.line_drive   = out_q.line_drive;
  assign res.clock_pulse  = out_q.clock_pulse;
  assign res.busy_res     = out_q.busy_res;
  assign res.done_res     = out_q.done_res;
  assign res.ack_code     = out_q.ack_code;
  assign res.read_word    = out_q.read_word;
  assign res.parity_fault = out_q.parity_fault;

endmodule

`default_nettype wire

FILE: hw/rtl/swd_checker.sv
// swd_checker: port-level assertions for the bit engine result channel
// bound to swd_master_bit_engine_core; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module swd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        line_out_i,
  input logic        line_drive_i,
  input logic        clock_pulse_i,
  input logic        busy_res_i,
  input logic        done_res_i,
  input logic [31:0] read_word_i
);

  // a held result keeps its read word and done flag
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(read_word_i) && $stable(done_res_i))
    else $error("result changed while stalled");

  // a finished sequence is never reported busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_res_i |-> !busy_res_i)
    else $error("done and busy together");

  // released line reads low
  a_release_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !line_drive_i |-> !line_out_i)
    else $error("line level without drive");

  // the line is only driven during a clock period
  a_drive_needs_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !clock_pulse_i |-> !line_drive_i)
    else $error("line driven without clock");

endmodule

bind swd_master_bit_engine_core swd_checker u_swd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .line_out_i    (res_o.line_out),
  .line_drive_i  (res_o.line_drive),
  .clock_pulse_i (res_o.clock_pulse),
  .busy_res_i    (res_o.busy_res),
  .done_res_i    (res_o.done_res),
  .read_word_i   (res_o.read_word)
);

`default_nettype wire

FILE: bench/swd_master_bit_engine_core_tb.sv
// swd_master_bit_engine_core_tb: self-checking bench for the serial wire debug bit engine
// depends on swd_pkg, swd_if and the engine rtl; a line-level predictor checks every result
`timescale 1ns / 1ps

module swd_master_bit_engine_core_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [2:0] LRST_LEN_ADDR = {swd_pkg::REG_LRST_LEN, 2'b00};

  // sequence the engine is stepping through
  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_XFER   = 2'd1,
    SEQ_LRST   = 2'd2,
    SEQ_SWITCH = 2'd3
  } seq_mode_e;

  // wire-level predictor plus the queue of line states still owed by the engine
  class swd_wire_board;
    logic [7:0]    reset_len  = swd_pkg::LRST_LEN_RESET;
    seq_mode_e     mode       = SEQ_IDLE;
    logic [7:0]    bit_pos    = '0;
    logic [7:0]    req_byte   = '0;
    logic [31:0]   shift_word = '0;
    logic [2:0]    ack        = '0;
    logic          par_acc    = 1'b0;
    logic          is_read    = 1'b0;
    swd_pkg::res_t owed_lines[$];
    int errors    = 0;
    int n_items   = 0;
    int n_xfer    = 0;
    int n_lrst    = 0;
    int n_switch  = 0;
    int n_checked = 0;
    int n_faults  = 0;

    function int pending();
      return owed_lines.size();
    endfunction

    // step the line state by one accepted item and queue the expected result
    function void note_item(swd_pkg::kind_e kind, logic ap, logic rnw, logic [1:0] addr,
                            logic [31:0] wdata, logic lin);
      swd_pkg::res_t r;
      int   p;
      logic done;
      r    = '0;
      done = 1'b0;
      n_items++;
      if (kind != swd_pkg::KIND_TICK) begin
        bit_pos = '0;
        ack     = '0;
        if (kind == swd_pkg::KIND_XFER) begin
          n_xfer++;
          req_byte   = {1'b1, 1'b0, ap ^ rnw ^ addr[0] ^ addr[1], addr[1], addr[0], rnw, ap, 1'b1};
          is_read    = rnw;
          shift_word = rnw ? 32'h0 : wdata;
          par_acc    = rnw ? 1'b0 : ^wdata;
          mode       = SEQ_XFER;
        end else begin
          is_read    = 1'b0;
          shift_word = '0;
          par_acc    = 1'b0;
          if (kind == swd_pkg::KIND_LRST) begin
            n_lrst++;
            mode = SEQ_LRST;
            // zero length ends on the command itself
            if (reset_len == 8'd0) begin
              mode = SEQ_IDLE;
              done = 1'b1;
            end
          end else begin
            n_switch++;
            mode = SEQ_SWITCH;
          end
        end
      end else if (mode != SEQ_IDLE) begin
        p = int'(bit_pos);
        r.clock_pulse = 1'b1;
        bit_pos = bit_pos + 8'd1;
        case (mode)
          SEQ_LRST: begin
            r.line_drive = 1'b1;
            r.line_out   = 1'b1;
            // live length, so a shortened length ends the reset at once
            if (p + 1 >= int'(reset_len)) done = 1'b1;
          end
          SEQ_SWITCH: begin
            r.line_drive = 1'b1;
            r.line_out   = swd_pkg::SWITCH_PATTERN[p % 16];
            if (p + 1 >= int'(swd_pkg::SWITCH_BITS)) done = 1'b1;
          end
          default: begin
            if (p < int'(swd_pkg::REQ_BITS)) begin
              r.line_drive = 1'b1;
              r.line_out   = req_byte[p];
            end else if (p == 8) begin
              // turnaround to target
            end else if (p <= 11) begin
              ack[p-9] = lin;
            end else if (is_read) begin
              if (p < 12 + int'(swd_pkg::WORD_BITS)) begin
                shift_word[p-12] = lin;
                par_acc = par_acc ^ lin;
              end else if (p == 44) begin
                par_acc = par_acc ^ lin;
              end else begin
                done = 1'b1;
              end
            end else begin
              if (p == 12) begin
                // turnaround back to master
              end else if (p < 13 + int'(swd_pkg::WORD_BITS)) begin
                r.line_drive = 1'b1;
                r.line_out   = shift_word[p-13];
              end else if (p == 45) begin
                r.line_drive = 1'b1;
                r.line_out   = par_acc;
              end else begin
                r.line_drive = 1'b1;
                r.line_out   = 1'b0;
                done = 1'b1;
              end
            end
          end
        endcase
        if (done) mode = SEQ_IDLE;
      end
      r.done_res     = done;
      r.busy_res     = (mode != SEQ_IDLE);
      r.ack_code     = ack;
      r.read_word    = is_read ? shift_word : 32'h0;
      r.parity_fault = (is_read && bit_pos >= 8'd45) ? par_acc : 1'b0;
      if (r.parity_fault && done) n_faults++;
      owed_lines.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    // compare one result transfer against the oldest owed line state
    function void check_result(swd_pkg::res_t got);
      swd_pkg::res_t want;
      if (owed_lines.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = owed_lines.pop_front();
      n_checked++;
      cmp("line_out", 32'(want.line_out), 32'(got.line_out));
      cmp("line_drive", 32'(want.line_drive), 32'(got.line_drive));
      cmp("clock_pulse", 32'(want.clock_pulse), 32'(got.clock_pulse));
      cmp("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      cmp("done_res", 32'(want.done_res), 32'(got.done_res));
      cmp("ack_code", 32'(want.ack_code), 32'(got.ack_code));
      cmp("read_word", want.read_word, got.read_word);
      cmp("parity_fault", 32'(want.parity_fault), 32'(got.parity_fault));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  swd_cmd_if cmd ();
  swd_res_if res ();

  swd_wire_board board = new();

  int send_pct    = 0;
  int recv_pct    = 0;
  int hold_cycles = 0;
  int items_sent  = 0;
  int cycles      = 0;

  swd_master_bit_engine_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, board.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // check each result transfer
  always @(posedge clk_i) begin
    swd_pkg::res_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.line_out     = res.line_out;
      got.line_drive   = res.line_drive;
      got.clock_pulse  = res.clock_pulse;
      got.busy_res     = res.busy_res;
      got.done_res     = res.done_res;
      got.ack_code     = res.ack_code;
      got.read_word    = res.read_word;
      got.parity_fault = res.parity_fault;
      board.check_result(got);
    end
  end

  // offer one item and hold it until the transfer happens
  task automatic push_item(swd_pkg::kind_e k, logic ap, logic rnw, logic [1:0] addr,
                           logic [31:0] wd, logic lin);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid          <= 1'b1;
    cmd.kind           <= k;
    cmd.ap_not_dp      <= ap;
    cmd.read_not_write <= rnw;
    cmd.reg_addr       <= addr;
    cmd.write_data     <= wd;
    cmd.line_in        <= lin;
    do @(posedge clk_i); while (!cmd.ready);
    board.note_item(k, ap, rnw, addr, wd, lin);
    items_sent++;
  endtask

  task automatic push_random(swd_pkg::kind_e k);
    push_item(k, 1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)),
              $urandom, 1'($urandom_range(1)));
  endtask

  // sender pause until every owed result is back
  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write of the line reset length, setup then access
  task automatic write_reset_length(logic [7:0] len);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LRST_LEN_ADDR;
    pwdata  <= {24'h0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.reset_len = len;
  endtask

  // mostly complete sequences with random content, some cut short, some noise
  task automatic random_sequence();
    int   pick;
    int   ticks;
    logic rnw;
    pick = $urandom_range(99);
    rnw  = 1'($urandom_range(1));
    if (pick < 52) begin
      push_item(swd_pkg::KIND_XFER, 1'($urandom_range(1)), rnw, 2'($urandom_range(3)),
                $urandom, 1'($urandom_range(1)));
      ticks = rnw ? 46 : 47;
    end else if (pick < 64) begin
      push_random(swd_pkg::KIND_SWITCH);
      ticks = 16;
    end else if (pick < 72) begin
      push_random(swd_pkg::KIND_LRST);
      ticks = int'(board.reset_len);
    end else if (pick < 90) begin
      push_random(swd_pkg::kind_e'($urandom_range(1, 3)));
      ticks = $urandom_range(0, 30);
    end else begin
      ticks = 0;
      repeat ($urandom_range(1, 4)) push_random(swd_pkg::kind_e'($urandom_range(3)));
    end
    repeat (ticks) push_random(swd_pkg::KIND_TICK);
  endtask

  task automatic run_phase(int s_pct, int r_pct, logic [7:0] len, bit hold_off);
    int phase_end;
    drain_results();
    write_reset_length(len);
    send_pct = s_pct;
    recv_pct = r_pct;
    if (hold_off) hold_cycles = HOLD_CYCLES;
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) random_sequence();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cmd.valid          <= 1'b0;
    cmd.kind           <= swd_pkg::KIND_TICK;
    cmd.ap_not_dp      <= 1'b0;
    cmd.read_not_write <= 1'b0;
    cmd.reg_addr       <= 2'd0;
    cmd.write_data     <= 32'h0;
    cmd.line_in        <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick while idle, then a zero length line reset
    push_random(swd_pkg::KIND_TICK);
    drain_results();
    write_reset_length(8'd0);
    push_random(swd_pkg::KIND_LRST);
    // length shortened to the count already sent while a reset is under way
    drain_results();
    write_reset_length(8'd5);
    push_random(swd_pkg::KIND_LRST);
    repeat (2) push_random(swd_pkg::KIND_TICK);
    drain_results();
    write_reset_length(8'd2);
    push_random(swd_pkg::KIND_TICK);
    // commands replacing a sequence in progress, field extremes
    push_random(swd_pkg::KIND_SWITCH);
    repeat (3) push_random(swd_pkg::KIND_TICK);
    push_item(swd_pkg::KIND_XFER, 1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, 1'b1);
    repeat (10) push_item(swd_pkg::KIND_TICK, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1);
    push_item(swd_pkg::KIND_XFER, 1'b0, 1'b1, 2'd0, 32'h0, 1'b0);
    repeat (2) push_item(swd_pkg::KIND_TICK, 1'b0, 1'b0, 2'd0, 32'h0, 1'b0);

    // random phases over the idling modes and length settings
    run_phase(0, 0, 8'd50, 1'b1);
    run_phase(60, 0, 8'd255, 1'b0);
    run_phase(0, 60, 8'($urandom_range(51, 254)), 1'b0);
    run_phase(10, 10, swd_pkg::LRST_LEN_RESET, 1'b0);
    drain_results();

    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
      board.errors++;
    end
    $display("run covered %0d items: %0d transfers, %0d line resets, %0d switch sequences",
             board.n_items, board.n_xfer, board.n_lrst, board.n_switch);
    $display("%0d results checked, %0d reads ended with a parity fault, reset lengths 0 to 255",
             board.n_checked, board.n_faults);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
